// ----- rtl/shc_pkg.sv -----
// Package for the stall homing calibrator: register indexes, reset values,
// phase codes, configuration and result types. No dependencies.
package shc_pkg;

  localparam int TICK_W   = 24;
  localparam int POS_W    = 23;
  localparam int PWR_W    = 7;
  localparam int THR_W    = 23;
  localparam int DRIVE_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

  localparam logic [TICK_W-1:0] INTERVAL_RST  = 24'd1000;
  localparam logic [POS_W-1:0]  TARGET_RST    = 23'd90;
  localparam logic [PWR_W-1:0]  POWER_RST     = 7'd10;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 23'd1;

  localparam logic [PWR_W-1:0] DRIVE_LIMIT = 7'd100;

  localparam logic [2:0] PH_SETUP   = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_BACK    = 3'd2;
  localparam logic [2:0] PH_STALLED = 3'd3;
  localparam logic [2:0] PH_FWD     = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  typedef struct packed {
    logic [TICK_W-1:0] interval_ticks;
    logic [POS_W-1:0]  target_position;
    logic [PWR_W-1:0]  homing_power;
    logic [THR_W-1:0]  stall_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] motor_power;
    logic                      brake_on;
    logic                      encoder_reset;
    logic                      tone_pulse;
    logic                      done_res;
  } res_t;

  // drive magnitude limited to DRIVE_LIMIT
  function automatic logic [DRIVE_W-1:0] clamp_mag(input logic [PWR_W-1:0] p);
    logic [PWR_W-1:0] m;
    m = (p > DRIVE_LIMIT) ? DRIVE_LIMIT : p;
    return {1'b0, m};
  endfunction

endpackage

// ----- rtl/shc_ifs.sv -----
// Channel interfaces for the stall homing calibrator: tick input, command
// output and configuration write. Depends on shc_pkg.
interface shc_tick_if #(parameter int COUNT_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic signed [COUNT_WIDTH-1:0] encoder_count;
  modport source (output valid, output encoder_count, input ready);
  modport sink (input valid, input encoder_count, output ready);
endinterface

interface shc_cmd_if;
  import shc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] motor_power;
  logic                      brake_on;
  logic                      encoder_reset;
  logic                      tone_pulse;
  logic                      done_res;
  modport source (output valid, output motor_power, output brake_on,
                  output encoder_reset, output tone_pulse, output done_res,
                  input ready);
  modport sink (input valid, input motor_power, input brake_on,
                input encoder_reset, input tone_pulse, input done_res,
                output ready);
endinterface

interface shc_cfg_if;
  import shc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/shc_cfg.sv -----
// Configuration register file of the stall homing calibrator.
// Depends on shc_pkg.
module shc_cfg
  import shc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_ticks  <= INTERVAL_RST;
      cfg.target_position <= TARGET_RST;
      cfg.homing_power    <= POWER_RST;
      cfg.stall_threshold <= THRESHOLD_RST;
    end else if (wr_valid) begin
      case (wr_index)
        REG_INTERVAL:  cfg.interval_ticks  <= wr_data[TICK_W-1:0];
        REG_TARGET:    cfg.target_position <= wr_data[POS_W-1:0];
        REG_POWER:     cfg.homing_power    <= wr_data[PWR_W-1:0];
        REG_THRESHOLD: cfg.stall_threshold <= wr_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/shc_core.sv -----
// Input register, phase state and per-tick update of the stall homing
// calibrator. Depends on shc_pkg.
module shc_core
  import shc_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  input  logic signed [COUNT_WIDTH-1:0] in_count,
  output logic                          in_ready,
  input  logic                          res_free,
  output logic                          res_load,
  output res_t                          res
);

  localparam int DW = (COUNT_WIDTH + 2 > POS_W + 2) ? COUNT_WIDTH + 2 : POS_W + 2;

  logic                          s1_valid;
  logic signed [COUNT_WIDTH-1:0] s1_count;

  logic [2:0]                    phase, phase_next;
  logic [TICK_W-1:0]             elapsed, elapsed_next, elapsed_inc;
  logic signed [COUNT_WIDTH-1:0] prev_count, prev_count_next;
  logic signed [DRIVE_W-1:0]     held_power, held_power_next;
  logic                          held_brake, held_brake_next;

  logic signed [DW-1:0] prev_x, cnt_x, diff, thr_x, tgt_x;
  logic [DRIVE_W-1:0]   mag;
  logic                 enc_rst, tone, done;

  assign res_load = s1_valid && res_free;
  assign in_ready = !s1_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (res_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_count <= in_count;
    end
  end

  always_comb begin
    prev_x = {{(DW-COUNT_WIDTH){prev_count[COUNT_WIDTH-1]}}, prev_count};
    cnt_x  = {{(DW-COUNT_WIDTH){s1_count[COUNT_WIDTH-1]}}, s1_count};
    diff   = prev_x - cnt_x;
    thr_x  = {{(DW-THR_W){1'b0}}, cfg.stall_threshold};
    tgt_x  = {{(DW-POS_W){1'b0}}, cfg.target_position};
    mag    = clamp_mag(cfg.homing_power);
    elapsed_inc = (elapsed != {TICK_W{1'b1}}) ? elapsed + 1'b1 : elapsed;

    phase_next      = phase;
    elapsed_next    = elapsed;
    prev_count_next = prev_count;
    held_power_next = held_power;
    held_brake_next = held_brake;
    enc_rst = 1'b0;
    tone    = 1'b0;
    done    = 1'b0;

    case (phase)
      PH_START: begin
        elapsed_next = '0;
        phase_next   = PH_BACK;
      end
      PH_BACK: begin
        held_power_next = -$signed(mag);
        elapsed_next    = elapsed_inc;
        if (elapsed_inc >= cfg.interval_ticks) begin
          if (diff < thr_x) begin
            phase_next = PH_STALLED;
          end else begin
            prev_count_next = s1_count;
            phase_next      = PH_START;
          end
        end
      end
      PH_STALLED: begin
        tone            = 1'b1;
        held_power_next = '0;
        enc_rst         = 1'b1;
        phase_next      = PH_FWD;
      end
      PH_FWD: begin
        held_power_next = $signed(mag);
        if (cnt_x >= tgt_x) begin
          tone            = 1'b1;
          held_power_next = '0;
          held_brake_next = 1'b1;
          enc_rst         = 1'b1;
          done            = 1'b1;
          phase_next      = PH_DONE;
        end
      end
      PH_DONE: begin
        held_power_next = '0;
        held_brake_next = 1'b1;
        done            = 1'b1;
      end
      default: begin
        elapsed_next = '0;
        enc_rst      = 1'b1;
        phase_next   = PH_START;
      end
    endcase

    res.motor_power   = held_power_next;
    res.brake_on      = held_brake_next;
    res.encoder_reset = enc_rst;
    res.tone_pulse    = tone;
    res.done_res      = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SETUP;
      elapsed    <= '0;
      prev_count <= '0;
      held_power <= '0;
      held_brake <= 1'b0;
    end else if (res_load) begin
      phase      <= phase_next;
      elapsed    <= elapsed_next;
      prev_count <= prev_count_next;
      held_power <= held_power_next;
      held_brake <= held_brake_next;
    end
  end

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE)
    else $error("done phase left");

  a_done_stopped: assert property (@(posedge clk) disable iff (rst)
    res_load && res.done_res |-> res.brake_on && res.motor_power == 0)
    else $error("done without brake and zero drive");

  a_drive_limit: assert property (@(posedge clk) disable iff (rst)
    res_load |-> res.motor_power <= 8'sd100 && res.motor_power >= -8'sd100)
    else $error("drive out of range");

  a_tone_stops: assert property (@(posedge clk) disable iff (rst)
    res_load && res.tone_pulse |-> res.encoder_reset && res.motor_power == 0)
    else $error("tone without stop and encoder reset");

endmodule

// ----- rtl/shc_out_reg.sv -----
// Result register of the stall homing calibrator; holds one command
// transaction until the sink takes it. Depends on shc_pkg.
module shc_out_reg
  import shc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t din,
  output logic free,
  output logic out_valid,
  input  logic out_ready,
  output res_t dout
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

// ----- rtl/stall_homing_calibrator.sv -----
// Top level of the stall homing calibrator: config registers, core and
// result register. Depends on shc_pkg, shc_ifs, shc_cfg, shc_core, shc_out_reg.
//
//   channel  dir  payload
//   tick     in   encoder_count
//   cmd      out  motor_power, brake_on, encoder_reset, tone_pulse, done_res
//   cfg      in   index, data (always ready)
//
// One transaction per cycle sustained while cmd is ready; a tick goes through the
// input register, then the result register after the phase update, to cmd.
// rst is synchronous: phase returns to setup, timer and held drive clear,
// config registers take their reset values.
// A stalled cmd holds its result; tick stays ready while the input register
// can drain into the result register.
module stall_homing_calibrator
  import shc_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input logic      clk,
  input logic      rst,
  shc_tick_if.sink tick,
  shc_cmd_if.source cmd,
  shc_cfg_if.sink  cfg
);

  cfg_t cfg_regs;
  res_t core_res, out_res;
  logic res_load, res_free;

  assign cfg.ready = 1'b1;

  shc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  shc_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .in_valid (tick.valid),
    .in_count (tick.encoder_count),
    .in_ready (tick.ready),
    .res_free (res_free),
    .res_load (res_load),
    .res      (core_res)
  );

  shc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .din       (core_res),
    .free      (res_free),
    .out_valid (cmd.valid),
    .out_ready (cmd.ready),
    .dout      (out_res)
  );

  assign cmd.motor_power   = out_res.motor_power;
  assign cmd.brake_on      = out_res.brake_on;
  assign cmd.encoder_reset = out_res.encoder_reset;
  assign cmd.tone_pulse    = out_res.tone_pulse;
  assign cmd.done_res      = out_res.done_res;

endmodule

// ----- verif/shc_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the stall homing calibrator: watches the tick, command and
// config channels, predicts every command and compares. Depends on shc_pkg, shc_ifs.
module shc_checker
  import shc_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  shc_tick_if  tick,
  shc_cmd_if   cmd,
  shc_cfg_if   cfg,
  output int   pending,
  output int   errors
);

  cfg_t                      regs;
  logic [2:0]                homing_phase;
  logic [TICK_W-1:0]         tick_timer;
  longint                    last_mark;
  logic signed [DRIVE_W-1:0] drive_level;
  logic                      brake_level;
  res_t                      pending_cmds[$];
  int                        mismatch_count = 0;

  assign errors = mismatch_count;

  task automatic check_field(input string name, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // one control tick through the homing sequence
  task automatic advance_homing(input logic signed [COUNT_WIDTH-1:0] enc, output res_t cmd_out);
    longint count;
    int     mag;
    count = longint'(enc);
    mag = (regs.homing_power > DRIVE_LIMIT) ? int'(DRIVE_LIMIT) : int'(regs.homing_power);
    cmd_out = '0;
    case (homing_phase)
      PH_START: begin
        tick_timer = '0;
        homing_phase = PH_BACK;
      end
      PH_BACK: begin
        drive_level = DRIVE_W'(-mag);
        if (tick_timer != '1) tick_timer = tick_timer + 1'b1;
        if (tick_timer >= regs.interval_ticks) begin
          if (last_mark - count < longint'(regs.stall_threshold)) begin
            homing_phase = PH_STALLED;
          end else begin
            last_mark = count;
            homing_phase = PH_START;
          end
        end
      end
      PH_STALLED: begin
        cmd_out.tone_pulse = 1'b1;
        cmd_out.encoder_reset = 1'b1;
        drive_level = '0;
        homing_phase = PH_FWD;
      end
      PH_FWD: begin
        drive_level = DRIVE_W'(mag);
        if (count >= longint'(regs.target_position)) begin
          cmd_out.tone_pulse = 1'b1;
          cmd_out.encoder_reset = 1'b1;
          cmd_out.done_res = 1'b1;
          drive_level = '0;
          brake_level = 1'b1;
          homing_phase = PH_DONE;
        end
      end
      PH_DONE: begin
        drive_level = '0;
        brake_level = 1'b1;
        cmd_out.done_res = 1'b1;
      end
      default: begin
        tick_timer = '0;
        cmd_out.encoder_reset = 1'b1;
        homing_phase = PH_START;
      end
    endcase
    cmd_out.motor_power = drive_level;
    cmd_out.brake_on = brake_level;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      regs = '{interval_ticks: INTERVAL_RST, target_position: TARGET_RST,
               homing_power: POWER_RST, stall_threshold: THRESHOLD_RST};
      homing_phase = PH_SETUP;
      tick_timer = '0;
      last_mark = 0;
      drive_level = '0;
      brake_level = 1'b0;
      pending_cmds.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_INTERVAL:  regs.interval_ticks = cfg.data[TICK_W-1:0];
          REG_TARGET:    regs.target_position = cfg.data[POS_W-1:0];
          REG_POWER:     regs.homing_power = cfg.data[PWR_W-1:0];
          REG_THRESHOLD: regs.stall_threshold = cfg.data[THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        if (pending_cmds.size() == 0) begin
          $error("command transaction with no tick outstanding");
          mismatch_count++;
        end else begin
          want = pending_cmds.pop_front();
          check_field("motor_power", want.motor_power, cmd.motor_power);
          check_field("brake_on", want.brake_on, cmd.brake_on);
          check_field("encoder_reset", want.encoder_reset, cmd.encoder_reset);
          check_field("tone_pulse", want.tone_pulse, cmd.tone_pulse);
          check_field("done_res", want.done_res, cmd.done_res);
        end
      end
      if (tick.valid && tick.ready) begin
        advance_homing(tick.encoder_count, want);
        pending_cmds.push_back(want);
      end
    end
    pending <= pending_cmds.size();
  end

endmodule

// ----- verif/stall_homing_calibrator_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the stall homing calibrator: clock, reset, tick and config
// stimulus, command back-pressure and verdict. Depends on shc_pkg, shc_ifs, shc_checker.
module stall_homing_calibrator_test;
  import shc_pkg::*;

  localparam int COUNT_W        = 24;
  localparam int IDLE_PCT       = 38;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int BACK_ITEMS     = 620;
  localparam int FWD_ITEMS      = 880;
  localparam int DONE_ITEMS     = 20;
  localparam int INTERVAL_MAX   = 16777215;
  localparam int POS_MAX        = 8388607;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady = 1'b0;
  int   errors;
  int   pending;
  int   quiet_cycles = 0;
  int   ticks_sent = 0;
  int   cur_interval;
  int   cur_target;
  int   cur_thresh;
  int   back_mark = 0;
  int   fwd_pos = 0;

  shc_tick_if #(.COUNT_WIDTH(COUNT_W)) tick_ch ();
  shc_cmd_if cmd_ch ();
  shc_cfg_if cfg_ch ();

  stall_homing_calibrator #(.COUNT_WIDTH(COUNT_W)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .tick (tick_ch.sink),
    .cmd  (cmd_ch.source),
    .cfg  (cfg_ch.sink)
  );

  shc_checker #(.COUNT_WIDTH(COUNT_W)) u_checker (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .cmd     (cmd_ch),
    .cfg     (cfg_ch),
    .pending (pending),
    .errors  (errors)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.ready <= 1'b0;
    end else begin
      cmd_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("stall_homing_calibrator_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [COUNT_W-1:0] noise_count();
    case ($urandom_range(9))
      0: return COUNT_MIN;
      1: return COUNT_MAX;
      2: return '0;
      3: return '1;
      default: return COUNT_W'($urandom);
    endcase
  endfunction

  function automatic int pick_power();
    case ($urandom_range(4))
      0: return 0;
      1: return 100;
      2: return 101;
      3: return 127;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  task automatic send_tick(input logic signed [COUNT_W-1:0] c);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.encoder_count <= c;
    do @(posedge clk); while (!(tick_ch.valid && tick_ch.ready));
    ticks_sent++;
  endtask

  task automatic drain_commands();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
  endtask

  task automatic set_config(input int ivl, input int tgt, input int pwr, input int thr);
    write_reg(REG_INTERVAL, ivl);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_POWER, pwr);
    write_reg(REG_THRESHOLD, thr);
    cfg_ch.valid <= 1'b0;
    cur_interval = ivl;
    cur_target = tgt;
    cur_thresh = thr;
  endtask

  // start tick, then one timed interval of backward drive that ends still moving
  task automatic back_cycle();
    int span;
    span = (cur_interval == 0) ? 1 : cur_interval;
    repeat (span) send_tick(noise_count());
    back_mark = back_mark - cur_thresh -
                (($urandom_range(3) == 0) ? 0 : int'($urandom_range(1, 40)));
    send_tick(COUNT_W'(back_mark));
  endtask

  initial begin
    int ivl;
    int thr;
    int tgt;
    int grp;
    int c;
    tick_ch.valid <= 1'b0;
    tick_ch.encoder_count <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset register values: setup, start, backward ticks mid-interval
    send_tick(COUNT_MIN);
    send_tick(COUNT_MAX);
    send_tick(24'h555555);
    send_tick(24'haaaaaa);
    send_tick('0);
    // zero interval closes at once; zero threshold with no change is still motion
    drain_commands();
    set_config(0, 90, 127, 0);
    send_tick('0);
    send_tick(COUNT_MAX);
    send_tick(-5);
    // change equal to threshold is still motion
    drain_commands();
    set_config(1, 90, 100, 1);
    send_tick(noise_count());
    send_tick(-6);
    // longest interval, then shrunk below the ticks already counted
    drain_commands();
    set_config(INTERVAL_MAX, 90, 0, 5);
    repeat (4) send_tick(noise_count());
    drain_commands();
    set_config(2, POS_MAX, 101, 5);
    send_tick(-11);
    back_mark = -11;

    grp = 0;
    while (ticks_sent < BACK_ITEMS) begin
      drain_commands();
      steady <= (grp == 2);
      case ($urandom_range(9))
        0: ivl = 0;
        1: ivl = 1;
        2: ivl = $urandom_range(20, 40);
        default: ivl = $urandom_range(2, 10);
      endcase
      case ($urandom_range(5))
        0: thr = 0;
        1: thr = 1;
        default: thr = $urandom_range(2, 200);
      endcase
      set_config(ivl, $urandom_range(0, POS_MAX), pick_power(), thr);
      repeat ($urandom_range(4, 25)) back_cycle();
      grp++;
    end

    // largest threshold forces the stall
    drain_commands();
    steady <= 1'b0;
    set_config($urandom_range(1, 4), POS_MAX, pick_power(), POS_MAX);
    repeat (cur_interval) send_tick(noise_count());
    send_tick(COUNT_W'(back_mark - int'($urandom_range(0, 1000))));
    send_tick(noise_count());

    while (ticks_sent < FWD_ITEMS) begin
      drain_commands();
      case ($urandom_range(3))
        0: tgt = 0;
        1: tgt = POS_MAX;
        default: tgt = $urandom_range(100, 100000);
      endcase
      set_config($urandom_range(0, 50), tgt, pick_power(), $urandom_range(0, POS_MAX));
      repeat ($urandom_range(5, 30)) begin
        fwd_pos += int'($urandom_range(0, 20));
        c = int'(noise_count());
        if ($urandom_range(9) < 7 && fwd_pos < cur_target) begin
          c = fwd_pos;
        end else if (c >= cur_target) begin
          c = -c - 1;
        end
        send_tick(COUNT_W'(c));
      end
    end

    // one below the target, then the target itself finishes
    drain_commands();
    tgt = fwd_pos + int'($urandom_range(50, 5000));
    set_config(cur_interval, tgt, pick_power(), cur_thresh);
    send_tick(COUNT_W'(tgt - 1));
    send_tick(COUNT_W'(tgt));
    repeat (DONE_ITEMS) send_tick(noise_count());

    drain_commands();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("stall_homing_calibrator_test: PASS");
    end else begin
      $display("stall_homing_calibrator_test: FAIL");
    end
    $finish;
  end

endmodule
